>>> hdl/bpm_pkg.sv
// -----------------------------------------------------------------------------
// bpm_pkg
// Shared types and constants of the byte pattern matcher: register indexes,
// field widths and the result record passed from the scanner to the top level.
// -----------------------------------------------------------------------------
package bpm_pkg;

   localparam int BYTE_W    = 8;
   localparam int PAT_W     = 64;
   localparam int LEN_W     = 4;
   localparam int WIN_W     = 16;
   localparam int NUM_W     = 16;
   localparam int OFS_W     = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_ADDR_W-1:0] CSR_PATTERN_BYTES  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PATTERN_LENGTH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_LENGTH  = 2'd2;

   localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = 4'd1;
   localparam logic [WIN_W-1:0] WINDOW_LENGTH_RST  = 16'd1;

   // one result of the scanner
   typedef struct packed {
      logic                    match_found;
      logic [NUM_W-1:0]        match_number;
      logic [OFS_W-1:0]        match_offset;
      logic                    capture_valid;
      logic [BYTE_W-1:0]       capture_byte;
      logic                    capture_last;
   } result_type;

endpackage

>>> hdl/bpm_scan.sv
// -----------------------------------------------------------------------------
// bpm_scan
// Scan state and per-byte evaluation: sliding history, fill count, capture
// window counter, stream offset and match counter.
// -----------------------------------------------------------------------------
module bpm_scan #(
   parameter int MAX_PATTERN = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [bpm_pkg::BYTE_W-1:0]      data_byte,
   input  logic [bpm_pkg::PAT_W-1:0]       pattern_bytes,
   input  logic [bpm_pkg::LEN_W-1:0]       pattern_length,
   input  logic [bpm_pkg::WIN_W-1:0]       window_length,
   output bpm_pkg::result_type             result
);

   localparam int FILL_W = $clog2(MAX_PATTERN + 1);

   logic [bpm_pkg::BYTE_W-1:0] hist_ff [MAX_PATTERN];
   logic [bpm_pkg::BYTE_W-1:0] hist_in [MAX_PATTERN];
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [bpm_pkg::WIN_W-1:0]  win_ff, win_in;
   logic [bpm_pkg::OFS_W-1:0]  ofs_ff, ofs_in;
   logic [bpm_pkg::NUM_W-1:0]  count_ff, count_in;

   logic [bpm_pkg::LEN_W-1:0]  act_len;
   logic [FILL_W-1:0]          fill_inc;
   logic [MAX_PATTERN-1:0]     len_hit;
   logic [MAX_PATTERN-1:0]     len_sel;
   logic                       hit;

   // pattern length clamped to 1..MAX_PATTERN
   always_comb begin
      if (pattern_length == '0) begin
         act_len = bpm_pkg::LEN_W'(1);
      end else if (pattern_length > bpm_pkg::LEN_W'(MAX_PATTERN)) begin
         act_len = bpm_pkg::LEN_W'(MAX_PATTERN);
      end else begin
         act_len = pattern_length;
      end
   end

   // history after shifting in the current byte, newest at index 0
   always_comb begin
      hist_in[0] = data_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         hist_in[j] = hist_ff[j-1];
      end
   end

   // one compare row per candidate length, pattern byte k against entry len-1-k
   always_comb begin
      for (int l = 1; l <= MAX_PATTERN; l++) begin
         len_hit[l-1] = 1'b1;
         for (int k = 0; k < l; k++) begin
            if (hist_in[l-1-k] != pattern_bytes[k*bpm_pkg::BYTE_W +: bpm_pkg::BYTE_W]) begin
               len_hit[l-1] = 1'b0;
            end
         end
         len_sel[l-1] = (act_len == bpm_pkg::LEN_W'(l));
      end
   end

   assign fill_inc = (fill_ff == FILL_W'(MAX_PATTERN)) ? fill_ff : fill_ff + 1'b1;
   assign hit      = (bpm_pkg::LEN_W'(fill_inc) >= act_len) && (|(len_hit & len_sel));

   always_comb begin
      result   = '0;
      fill_in  = fill_ff;
      win_in   = win_ff;
      count_in = count_ff;
      ofs_in   = ofs_ff + 1'b1;
      if (win_ff != '0) begin
         win_in               = win_ff - 1'b1;
         result.capture_valid = 1'b1;
         result.capture_byte  = data_byte;
         result.capture_last  = (win_ff == bpm_pkg::WIN_W'(1));
      end else begin
         fill_in = fill_inc;
         if (hit) begin
            count_in            = count_ff + 1'b1;
            result.match_found  = 1'b1;
            result.match_number = count_ff + 1'b1;
            result.match_offset = ofs_ff - (bpm_pkg::OFS_W'(act_len) - 1'b1);
            win_in              = window_length;
            // entries past the fill count are never compared, so only the count clears
            fill_in             = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         win_ff   <= '0;
         ofs_ff   <= '0;
         count_ff <= '0;
      end else if (step) begin
         fill_ff  <= fill_in;
         win_ff   <= win_in;
         ofs_ff   <= ofs_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && (win_ff == '0)) begin
         hist_ff <= hist_in;
      end
   end

endmodule

>>> hdl/byte_pattern_match_capture.sv
// -----------------------------------------------------------------------------
// byte_pattern_match_capture
// Scans a byte stream for a programmable 1..8 byte pattern, reports each match
// with its number and start offset, then passes on a capture window of bytes.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | tdata: data_byte
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata/tuser/tlast: match and capture
//   csr     | in  | csr_we                 | csr_addr, csr_wdata
//
// One byte per cycle unless rsp stalls; req passes input then output register.
// The history compare and window counter update in the cycle a byte leaves
// the input register. Synchronous reset restores the registers to pattern 0,
// length 1, window 1 and empties both stages. A stalled rsp holds its data,
// and req keeps accepting while the input register can move on.
// -----------------------------------------------------------------------------
module byte_pattern_match_capture #(
   parameter int MAX_PATTERN = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] data_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [55:0]                         rsp_tdata,   // [15:0] match_number,
                                                            // [47:16] match_offset,
                                                            // [55:48] capture_byte
   output logic [1:0]                          rsp_tuser,   // [0] match_found,
                                                            // [1] capture_valid
   output logic                                rsp_tlast,   // capture_last
   input  logic                                csr_we,
   input  logic [bpm_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [bpm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [bpm_pkg::PAT_W-1:0]  pat_ff;
   logic [bpm_pkg::LEN_W-1:0]  plen_ff;
   logic [bpm_pkg::WIN_W-1:0]  wlen_ff;

   logic                       in_vld_ff;
   logic [bpm_pkg::BYTE_W-1:0] in_byte_ff;
   logic                       out_vld_ff;
   bpm_pkg::result_type        out_res_ff;
   bpm_pkg::result_type        scan_res;
   logic                       out_free;
   logic                       advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         plen_ff <= bpm_pkg::PATTERN_LENGTH_RST;
         wlen_ff <= bpm_pkg::WINDOW_LENGTH_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            bpm_pkg::CSR_PATTERN_BYTES:  pat_ff  <= csr_wdata;
            bpm_pkg::CSR_PATTERN_LENGTH: plen_ff <= csr_wdata[bpm_pkg::LEN_W-1:0];
            bpm_pkg::CSR_WINDOW_LENGTH:  wlen_ff <= csr_wdata[bpm_pkg::WIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free   = !out_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   bpm_scan #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .data_byte      (in_byte_ff),
      .pattern_bytes  (pat_ff),
      .pattern_length (plen_ff),
      .window_length  (wlen_ff),
      .result         (scan_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_free) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= scan_res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_res_ff.capture_byte, out_res_ff.match_offset,
                        out_res_ff.match_number};
   assign rsp_tuser  = {out_res_ff.capture_valid, out_res_ff.match_found};
   assign rsp_tlast  = out_res_ff.capture_last;

endmodule

>>> hdl/bpm_checker.sv
// -----------------------------------------------------------------------------
// bpm_checker
// Port-level checks of the pattern matcher's result stream, bound to the top.
// -----------------------------------------------------------------------------
module bpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // matching is off inside a capture window
   a_no_match_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("match reported inside capture window");

   a_last_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1])
      else $error("capture last outside a window");

   a_match_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[47:0] == 48'd0)
      else $error("match fields set without a match");

   a_capture_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[55:48] == 8'd0 && !rsp_tlast)
      else $error("capture fields set outside a window");

endmodule

bind byte_pattern_match_capture bpm_checker u_bpm_checker (.*);
